>>> design/cmas_pkg.sv
// ---------------------------------------------------------------------------
// cmas_pkg
// Shared widths, constants and link types of the compass median smoother.
// ---------------------------------------------------------------------------
package cmas_pkg;

   // Window geometry
   localparam int WINDOW_HALF  = 5;
   localparam int WINDOW_TOTAL = 2 * WINDOW_HALF - 1;
   localparam int SLOT_W       = (WINDOW_TOTAL > 1) ? $clog2(WINDOW_TOTAL) : 1;
   localparam int CNT_W        = $clog2(WINDOW_TOTAL + 1);

   // Field widths
   localparam int HEAD_W = 12;
   localparam int VAL_W  = 13;
   localparam int GAIN_W = 16;
   localparam int FRAC_W = 16;
   localparam int AVG_W  = 28;

   // Heading constants, tenths of a degree
   localparam int FULL_TURN = 3600;
   localparam int HALF_TURN = 1800;
   localparam int SENTINEL  = 4500;

   localparam logic [HEAD_W-1:0] FULL_TURN_H = HEAD_W'(FULL_TURN);
   localparam logic [VAL_W-1:0]  SENTINEL_V  = VAL_W'(SENTINEL);
   localparam logic [AVG_W-1:0]  FULL_Q      = AVG_W'(FULL_TURN * (2 ** FRAC_W));
   localparam logic [AVG_W-1:0]  HALF_Q      = AVG_W'(HALF_TURN * (2 ** FRAC_W));
   localparam logic [GAIN_W-1:0] GAIN_RESET  = GAIN_W'(1966);

   // One stored window element: sample value, age slot it came in on, occupied
   typedef struct packed {
      logic [VAL_W-1:0]  value;
      logic [SLOT_W-1:0] slot;
      logic              valid;
   } entry_type;

   localparam entry_type EMPTY_ENTRY = '{value: SENTINEL_V, slot: '0, valid: 1'b0};

   // Broadcast to every cell of the window
   typedef struct packed {
      logic              load;
      logic              full;
      logic [VAL_W-1:0]  value;
      logic [SLOT_W-1:0] slot;
   } bcast_type;

   // Link from a cell to the next higher cell
   typedef struct packed {
      entry_type entry;   // compacted element at this position
      logic      le;      // that element is not above the new sample
      logic      gone;    // the evicted element sits at or below this position
   } link_type;

   // Median tap of the window
   typedef struct packed {
      logic              valid;
      logic [HEAD_W-1:0] value;
   } median_type;

   // Step strobes into the smoothing datapath
   typedef struct packed {
      logic diff;
      logic fold;
      logic mul;
      logic sum;
   } step_type;

endpackage

>>> design/cmas_req_if.sv
// ---------------------------------------------------------------------------
// cmas_req_if
// Input channel: one heading sample and mode bit per item.
// ---------------------------------------------------------------------------
interface cmas_req_if;
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic [cmas_pkg::HEAD_W-1:0] heading_sample;

   modport source (output valid, op, heading_sample, input ready);
   modport sink   (input valid, op, heading_sample, output ready);
endinterface

>>> design/cmas_rsp_if.sv
// ---------------------------------------------------------------------------
// cmas_rsp_if
// Result channel: smoothed heading and window median per item.
// ---------------------------------------------------------------------------
interface cmas_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [cmas_pkg::HEAD_W-1:0] heading_out;
   logic [cmas_pkg::HEAD_W-1:0] median_out;
   logic                        median_valid;

   modport source (output valid, heading_out, median_out, median_valid, input ready);
   modport sink   (input valid, heading_out, median_out, median_valid, output ready);
endinterface

>>> design/cmas_cell.sv
// ---------------------------------------------------------------------------
// cmas_cell
// One position of the sorted window: evict, compact and insert in one step.
// ---------------------------------------------------------------------------
module cmas_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  cmas_pkg::bcast_type  bcast,
   input  cmas_pkg::link_type   lo_link,   // from the cell below
   input  cmas_pkg::entry_type  hi_entry,  // stored element of the cell above
   output cmas_pkg::link_type   hi_link,   // to the cell above
   output cmas_pkg::entry_type  entry
);

   cmas_pkg::entry_type ent_ff;
   cmas_pkg::entry_type ent_in;
   cmas_pkg::entry_type packed_ent;
   cmas_pkg::entry_type new_ent;
   logic                evict;
   logic                gone;
   logic                packed_le;

   always_comb begin
      // the oldest element leaves; everything above it slides down one place
      evict      = bcast.full && ent_ff.valid && (ent_ff.slot == bcast.slot);
      gone       = lo_link.gone || evict;
      packed_ent = gone ? hi_entry : ent_ff;
      packed_le  = (packed_ent.value <= bcast.value);

      new_ent.value = bcast.value;
      new_ent.slot  = bcast.slot;
      new_ent.valid = 1'b1;

      // keep, take the new sample, or take the one from below
      priority if (packed_le) begin
         ent_in = packed_ent;
      end else if (lo_link.le) begin
         ent_in = new_ent;
      end else begin
         ent_in = lo_link.entry;
      end

      hi_link.entry = packed_ent;
      hi_link.le    = packed_le;
      hi_link.gone  = gone;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff <= cmas_pkg::EMPTY_ENTRY;
      end else if (bcast.load) begin
         ent_ff <= ent_in;
      end
   end

   assign entry = ent_ff;

endmodule

>>> design/cmas_window.sv
// ---------------------------------------------------------------------------
// cmas_window
// Row of sorted cells with age slot counter and fill count; median tap.
// ---------------------------------------------------------------------------
module cmas_window (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic [cmas_pkg::HEAD_W-1:0] sample,
   output cmas_pkg::median_type        median
);

   localparam int WT = cmas_pkg::WINDOW_TOTAL;

   logic [cmas_pkg::SLOT_W-1:0] oldest_ff, oldest_in;
   logic [cmas_pkg::CNT_W-1:0]  fill_ff, fill_in;
   logic                        full;
   cmas_pkg::bcast_type         bcast;
   cmas_pkg::link_type          link [WT+1];
   cmas_pkg::entry_type         ent  [WT+1];

   assign full = (fill_ff == cmas_pkg::CNT_W'(WT));

   always_comb begin
      bcast.load  = load;
      bcast.full  = full;
      bcast.value = cmas_pkg::VAL_W'(sample);
      bcast.slot  = oldest_ff;
   end

   // chain ends: nothing below the first cell, an empty slot above the last
   always_comb begin
      link[0].entry = cmas_pkg::EMPTY_ENTRY;
      link[0].le    = 1'b1;
      link[0].gone  = 1'b0;
      ent[WT]       = cmas_pkg::EMPTY_ENTRY;
   end

   for (genvar i = 0; i < WT; i++) begin : g_cell
      cmas_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .bcast    (bcast),
         .lo_link  (link[i]),
         .hi_entry (ent[i+1]),
         .hi_link  (link[i+1]),
         .entry    (ent[i])
      );
   end

   always_comb begin
      oldest_in = oldest_ff;
      fill_in   = fill_ff;
      if (load) begin
         oldest_in = (oldest_ff == cmas_pkg::SLOT_W'(WT - 1)) ? '0
                                                              : oldest_ff + 1'b1;
         if (!full) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         fill_ff   <= '0;
      end else begin
         oldest_ff <= oldest_in;
         fill_ff   <= fill_in;
      end
   end

   always_comb begin
      median.valid = full;
      median.value = ent[cmas_pkg::WINDOW_HALF-1].value[cmas_pkg::HEAD_W-1:0];
   end

endmodule

>>> design/cmas_smoother.sv
// ---------------------------------------------------------------------------
// cmas_smoother
// Running average: angular difference, fold, gain multiply, wrapped sum.
// ---------------------------------------------------------------------------
module cmas_smoother (
   input  logic                        clock,
   input  logic                        reset,
   input  cmas_pkg::step_type          step,
   input  logic                        op,
   input  logic [cmas_pkg::HEAD_W-1:0] sample,
   input  cmas_pkg::median_type        median,
   input  logic [cmas_pkg::GAIN_W-1:0] gain,
   output logic [cmas_pkg::HEAD_W-1:0] heading
);

   localparam int AW = cmas_pkg::AVG_W;
   localparam int FW = cmas_pkg::FRAC_W;
   localparam int PW = AW + cmas_pkg::GAIN_W;

   logic [AW-1:0]        avg_ff, avg_in;
   logic signed [AW:0]   diff_ff;
   logic [AW-1:0]        mag_ff;
   logic                 pos_ff;
   logic [AW-1:0]        delta_ff;

   logic [AW:0]          mag_abs;
   logic                 across;
   logic [PW-1:0]        prod;
   logic signed [AW+1:0] sum;
   logic signed [AW+1:0] sum_wrap;
   logic signed [AW+1:0] full_s;

   always_comb begin
      mag_abs = diff_ff[AW] ? (AW+1)'(-diff_ff) : diff_ff;
      across  = (mag_abs > {1'b0, cmas_pkg::HALF_Q});
      prod    = PW'(mag_ff) * PW'(gain);
      full_s  = $signed({2'b00, cmas_pkg::FULL_Q});
      sum     = pos_ff ? $signed({2'b00, avg_ff}) + $signed({2'b00, delta_ff})
                       : $signed({2'b00, avg_ff}) - $signed({2'b00, delta_ff});
      priority if (sum > full_s) begin
         sum_wrap = sum - full_s;
      end else if (sum < 0) begin
         sum_wrap = sum + full_s;
      end else begin
         sum_wrap = sum;
      end

      avg_in = avg_ff;
      if (step.sum) begin
         if (!op) begin
            avg_in = {sample, {FW{1'b0}}};
         end else if (median.valid) begin
            avg_in = sum_wrap[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff <= '0;
      end else begin
         avg_ff <= avg_in;
      end
   end

   // datapath stages
   always_ff @(posedge clock) begin
      if (step.diff) begin
         diff_ff <= $signed({1'b0, median.value, {FW{1'b0}}}) - $signed({1'b0, avg_ff});
      end
      if (step.fold) begin
         // across zero: take the short way round; a half turn stays put
         mag_ff <= across ? cmas_pkg::FULL_Q - mag_abs[AW-1:0] : mag_abs[AW-1:0];
         pos_ff <= across ? diff_ff[AW] : (!diff_ff[AW] && (diff_ff != '0));
      end
      if (step.mul) begin
         delta_ff <= prod[PW-1:FW];
      end
   end

   assign heading = avg_ff[AW-1:FW];

endmodule

>>> design/compass_median_angular_smoother_core.sv
// ---------------------------------------------------------------------------
// compass_median_angular_smoother_core
// Median-of-window compass filter with angular exponential smoothing.
// ---------------------------------------------------------------------------
// Each accepted item carries one heading in tenths of a degree (3600..4095
// fold back by a full turn) and a mode bit. The sample replaces the oldest of
// the last WINDOW_TOTAL samples in a row of sorting cells; once the row is
// full its middle cell is the median. Mode 0 loads the running average with
// the sample; mode 1 moves the average toward the median by the shortest
// signed angular difference times csr_wr_data's Q0.16 gain and wraps it into
// 0..3600 (left alone until the median is valid). Per item: the accept edge
// updates the window, then difference, fold, multiply, wrapped sum, and a
// load into the result register. The next item is taken once that result
// register is loaded, so items do not overlap; a stalled result holds the
// block in its output step. The gain written on the csr port applies from the
// next item if the user writes it while idle; the block does not enforce it.
// ---------------------------------------------------------------------------
module compass_median_angular_smoother_core (
   input  logic                        clock,
   input  logic                        reset,
   cmas_req_if.sink                    req_chan,
   cmas_rsp_if.source                  rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [cmas_pkg::GAIN_W-1:0] csr_wr_data
);

   // one-hot sequencer
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_DIFF = 6'b000010,
      ST_FOLD = 6'b000100,
      ST_MUL  = 6'b001000,
      ST_SUM  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type                   state_ff, state_in;
   logic [cmas_pkg::GAIN_W-1:0] gain_ff;
   logic                        op_ff;
   logic [cmas_pkg::HEAD_W-1:0] sample_ff;
   logic [cmas_pkg::HEAD_W-1:0] sample_fold;
   logic                        accept;
   logic                        out_free;
   logic                        out_load;
   cmas_pkg::step_type          step;
   cmas_pkg::median_type        median;
   logic [cmas_pkg::HEAD_W-1:0] heading;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [cmas_pkg::HEAD_W-1:0] rsp_heading_ff;
   logic [cmas_pkg::HEAD_W-1:0] rsp_median_ff;
   logic                        rsp_mvalid_ff;

   // fold out-of-range headings back by a full turn
   assign sample_fold = (req_chan.heading_sample >= cmas_pkg::FULL_TURN_H)
                        ? req_chan.heading_sample - cmas_pkg::FULL_TURN_H
                        : req_chan.heading_sample;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign out_load       = (state_ff == ST_OUT) && out_free;

   always_comb begin
      step.diff = (state_ff == ST_DIFF);
      step.fold = (state_ff == ST_FOLD);
      step.mul  = (state_ff == ST_MUL);
      step.sum  = (state_ff == ST_SUM);
   end

   // advance one step a cycle; hold in the output step while the result waits
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DIFF;
         end
         ST_DIFF: state_in = ST_FOLD;
         ST_FOLD: state_in = ST_MUL;
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         gain_ff  <= cmas_pkg::GAIN_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            gain_ff <= csr_wr_data;
         end
      end
   end

   // hold the item's mode and folded sample for the smoothing steps
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_chan.op;
         sample_ff <= sample_fold;
      end
   end

   cmas_window u_window (
      .clock  (clock),
      .reset  (reset),
      .load   (accept),
      .sample (sample_fold),
      .median (median)
   );

   cmas_smoother u_smoother (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .op      (op_ff),
      .sample  (sample_ff),
      .median  (median),
      .gain    (gain_ff),
      .heading (heading)
   );

   // result register: drop valid once taken, load a fresh item when free
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_heading_ff <= heading;
         rsp_median_ff  <= median.valid ? median.value : '0;
         rsp_mvalid_ff  <= median.valid;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.heading_out  = rsp_heading_ff;
   assign rsp_chan.median_out   = rsp_median_ff;
   assign rsp_chan.median_valid = rsp_mvalid_ff;

endmodule

>>> tb/cmas_tb_pkg.sv
// ---------------------------------------------------------------------------
// cmas_tb_pkg
// Mode codes, result record and gain limits shared by the testbench files.
// ---------------------------------------------------------------------------
package cmas_tb_pkg;

   typedef enum logic {
      HEADING_RAW    = 1'b0,
      HEADING_SMOOTH = 1'b1
   } heading_mode_type;

   typedef struct packed {
      logic [cmas_pkg::HEAD_W-1:0] heading;
      logic [cmas_pkg::HEAD_W-1:0] median;
      logic                        median_valid;
   } heading_result_type;

   localparam logic [cmas_pkg::GAIN_W-1:0] GAIN_MIN  = '0;
   localparam logic [cmas_pkg::GAIN_W-1:0] GAIN_MAX  = '1;
   localparam logic [cmas_pkg::GAIN_W-1:0] GAIN_HALF = 16'h8000;

endpackage

>>> tb/cmas_checker.sv
// ---------------------------------------------------------------------------
// cmas_checker
// Watches the sample and result channels, predicts each result from its own
// copy of the window, average and gain, and compares field by field.
// ---------------------------------------------------------------------------
module cmas_checker
   import cmas_pkg::*;
   import cmas_tb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   cmas_req_if               req_mon,
   cmas_rsp_if               rsp_mon,
   input  logic              csr_wr_en,
   input  logic [GAIN_W-1:0] csr_wr_data,
   output int                mismatch_count,
   output int                results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint FULL_L = longint'(FULL_Q);
   localparam longint HALF_L = longint'(HALF_Q);

   logic [HEAD_W-1:0]  recent_samples [WINDOW_TOTAL];
   int                 next_slot;
   int                 samples_held;
   logic [AVG_W-1:0]   average_q;
   logic [GAIN_W-1:0]  gain_q;
   heading_result_type expected_results [$];
   heading_result_type predicted;
   int                 n_mismatch = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      n_mismatch++;
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // Move the average toward the median along the shorter way round the dial.
   function automatic logic [AVG_W-1:0] smooth_toward_median(
      input logic [AVG_W-1:0]  avg,
      input logic [HEAD_W-1:0] med,
      input logic [GAIN_W-1:0] gain
   );
      longint target;
      longint now_q;
      longint span;
      longint step;
      longint total;
      logic   wraps;
      logic   upward;
      target = longint'(med) * (longint'(1) << FRAC_W);
      now_q  = longint'(avg);
      span   = (target > now_q) ? target - now_q : now_q - target;
      wraps  = 1'b0;
      if (span > HALF_L) begin
         span  = (span > FULL_L) ? span - FULL_L : FULL_L - span;
         wraps = 1'b1;
      end
      upward = wraps ? (target < now_q) : (target > now_q);
      // truncate the magnitude before applying the sign
      step   = (span * longint'(gain)) >> FRAC_W;
      total  = upward ? now_q + step : now_q - step;
      if (total > FULL_L) begin
         total = total - FULL_L;
      end else if (total < 0) begin
         total = total + FULL_L;
      end
      return AVG_W'(total);
   endfunction

   // Take one sample into the window and work out the result it yields.
   task automatic advance_filter(
      input  heading_mode_type   mode,
      input  logic [HEAD_W-1:0]  raw,
      output heading_result_type res
   );
      logic [HEAD_W-1:0] ordered [WINDOW_TOTAL];
      logic [HEAD_W-1:0] key;
      logic [HEAD_W-1:0] sample;
      logic [HEAD_W-1:0] median;
      int                i;
      int                j;
      sample = (raw >= FULL_TURN_H) ? raw - FULL_TURN_H : raw;
      recent_samples[next_slot] = sample;
      next_slot = (next_slot == WINDOW_TOTAL - 1) ? 0 : next_slot + 1;
      if (samples_held < WINDOW_TOTAL) begin
         samples_held++;
      end
      median = '0;
      if (samples_held == WINDOW_TOTAL) begin
         ordered = recent_samples;
         for (i = 1; i < WINDOW_TOTAL; i++) begin
            key = ordered[i];
            j = i - 1;
            while (j >= 0 && ordered[j] > key) begin
               ordered[j + 1] = ordered[j];
               j--;
            end
            ordered[j + 1] = key;
         end
         median = ordered[WINDOW_HALF - 1];
      end
      if (mode == HEADING_RAW) begin
         average_q = AVG_W'(sample) << FRAC_W;
      end else if (samples_held == WINDOW_TOTAL) begin
         average_q = smooth_toward_median(average_q, median, gain_q);
      end
      res.heading      = average_q[AVG_W-1:FRAC_W];
      res.median       = median;
      res.median_valid = (samples_held == WINDOW_TOTAL);
   endtask

   task automatic check_result();
      heading_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("result with no item outstanding", rsp_mon.heading_out, -1);
         return;
      end
      want = expected_results.pop_front();
      if (rsp_mon.heading_out !== want.heading) begin
         report_mismatch("heading_out", rsp_mon.heading_out, want.heading);
      end
      if (rsp_mon.median_out !== want.median) begin
         report_mismatch("median_out", rsp_mon.median_out, want.median);
      end
      if (rsp_mon.median_valid !== want.median_valid) begin
         report_mismatch("median_valid", rsp_mon.median_valid, want.median_valid);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WINDOW_TOTAL; k++) begin
            recent_samples[k] = '0;
         end
         next_slot    = 0;
         samples_held = 0;
         average_q    = '0;
         gain_q       = GAIN_RESET;
         expected_results.delete();
      end else begin
         if (csr_wr_en) begin
            gain_q = csr_wr_data;
         end
         // retire before predicting, so a result never meets its own item
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_result();
         end
         if (req_mon.valid && req_mon.ready) begin
            advance_filter(heading_mode_type'(req_mon.op), req_mon.heading_sample,
                           predicted);
            expected_results.push_back(predicted);
         end
      end
      mismatch_count <= n_mismatch;
      results_owed   <= expected_results.size();
   end

endmodule

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the compass median smoother: a directed opening,
// then random heading tracks under three idle profiles and several gains.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cmas_pkg::*;
   import cmas_tb_pkg::*;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [GAIN_W-1:0] csr_wr_data;
   int                mismatch_count;
   int                results_owed;
   int                req_idle_pct;
   int                rsp_stall_pct;

   cmas_req_if req_chan ();
   cmas_rsp_if rsp_chan ();

   compass_median_angular_smoother_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   cmas_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   always #1 clock = ~clock;

   // Result side: stall at random according to the current profile.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Offer one item, with random idle cycles in front of it, and hold it
   // until the edge that accepts it. Called just after a rising edge.
   task automatic send_item(input heading_mode_type mode, input logic [HEAD_W-1:0] sample);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.op             <= mode;
      req_chan.heading_sample <= sample;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Drop valid and hold until every outstanding result has come back.
   // The first edge lets the checker count the item accepted just before.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
      repeat (4) @(posedge clock);
   endtask

   // The gain may only change while the block is idle.
   task automatic write_gain(input logic [GAIN_W-1:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_directed();
      // smoothing before the window is full: the average must stay put
      send_item(HEADING_SMOOTH, 12'd100);
      // out-of-range samples fold back by a full turn
      send_item(HEADING_RAW, 12'd4095);
      send_item(HEADING_SMOOTH, 12'd3600);
      send_item(HEADING_RAW, 12'd3599);
      // fill the window; equal samples pile up beside each other
      repeat (9) send_item(HEADING_RAW, 12'd1800);
      // average at zero, median at 1800: exactly half a turn apart, no wrap
      send_item(HEADING_RAW, 12'd0);
      send_item(HEADING_SMOOTH, 12'd1800);
      // drag the median down near zero, then sit the average just below 3600
      repeat (6) send_item(HEADING_SMOOTH, 12'd5);
      send_item(HEADING_RAW, 12'd3595);
      // shortest way to the median now crosses north
      send_item(HEADING_SMOOTH, 12'd10);
      send_item(HEADING_SMOOTH, 12'd3598);
   endtask

   // Random heading tracks: a slowly turning heading with jitter, the odd
   // wide swing, and some samples drawn over the whole 12-bit field.
   task automatic run_random(input int count);
      int                sent;
      int                track_len;
      int                centre;
      int                spread;
      int                offset;
      int                i;
      logic [HEAD_W-1:0] sample;
      heading_mode_type  mode;
      sent = 0;
      while (sent < count) begin
         track_len = $urandom_range(60, 5);
         centre    = $urandom_range(FULL_TURN - 1);
         spread    = ($urandom_range(9) == 0) ? $urandom_range(HALF_TURN) : $urandom_range(40);
         for (i = 0; i < track_len && sent < count; i++) begin
            if ($urandom_range(99) < 6) begin
               sample = HEAD_W'($urandom_range((1 << HEAD_W) - 1));
            end else begin
               offset = int'($urandom_range(2 * spread)) - spread;
               sample = HEAD_W'((centre + offset + FULL_TURN) % FULL_TURN);
            end
            // advance the track heading a little, both ways round
            centre = (centre + int'($urandom_range(6)) - 3 + FULL_TURN) % FULL_TURN;
            mode   = ($urandom_range(99) < 15) ? HEADING_RAW : HEADING_SMOOTH;
            send_item(mode, sample);
            sent++;
            // now and then hold the sender until the block has emptied
            if ($urandom_range(299) == 0) begin
               drain_results();
            end
         end
      end
   endtask

   initial begin
      reset                   <= 1'b1;
      csr_wr_en               <= 1'b0;
      csr_wr_data             <= '0;
      req_chan.valid          <= 1'b0;
      req_chan.op             <= HEADING_RAW;
      req_chan.heading_sample <= '0;
      req_idle_pct  = 11;
      rsp_stall_pct = 58;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // sender mostly busy, receiver stalling often; reset gain first
      run_directed();
      run_random(320);
      write_gain(GAIN_MAX);
      run_random(320);

      // sender idling often, receiver mostly ready
      req_idle_pct  = 58;
      rsp_stall_pct = 11;
      write_gain(GAIN_MIN);
      run_random(320);
      write_gain(GAIN_W'($urandom()));
      run_random(320);

      // full rate both ways
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      write_gain(GAIN_HALF);
      run_random(300);
      write_gain(GAIN_W'($urandom_range(4000, 1)));
      run_random(300);

      drain_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Hard stop far beyond the slowest legal run.
   initial begin
      #1_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

>>> sim.f
design/cmas_pkg.sv
design/cmas_req_if.sv
design/cmas_rsp_if.sv
design/cmas_cell.sv
design/cmas_window.sv
design/cmas_smoother.sv
design/compass_median_angular_smoother_core.sv
tb/cmas_tb_pkg.sv
tb/cmas_checker.sv
tb/tb_top.sv
